FILE: hw/rtl/cvg_pkg.sv
// ----------------------------------------------------------------------------
// cvg_pkg
// Shared types, constants and saturation helpers for the circle vertex
// generator.
// ----------------------------------------------------------------------------
package cvg_pkg;

	localparam int CVG_MAX_SEGMENTS = 64;
	localparam int SEG_W            = 7;
	localparam int FACTOR_W         = 31;
	localparam int OFF_W            = 40;
	localparam int COORD_W          = 32;
	localparam int RADIUS_W         = 31;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 32;

	localparam logic [SEG_W-1:0]    SEG_RESET = 7'd64;
	localparam logic [FACTOR_W-1:0] TAN_RESET = 31'd105754339;
	localparam logic [FACTOR_W-1:0] COS_RESET = 31'd1068571454;

	localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_TANGENT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_COSINE   = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic [RADIUS_W-1:0]       radius;
	} cvg_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic                      last_vertex;
	} cvg_out_t;

	// clamp a 43-bit signed value to the 40-bit offset range
	function automatic logic signed [OFF_W-1:0] sat40(input logic signed [42:0] v);
		if ((v[42:39] == 4'b0000) || (v[42:39] == 4'b1111)) begin
			return v[OFF_W-1:0];
		end else if (v[42]) begin
			return {1'b1, {(OFF_W-1){1'b0}}};
		end else begin
			return {1'b0, {(OFF_W-1){1'b1}}};
		end
	endfunction

	// clamp a 42-bit signed value to the 32-bit vertex range
	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [41:0] v);
		if ((v[41:31] == 11'h000) || (v[41:31] == 11'h7FF)) begin
			return v[COORD_W-1:0];
		end else if (v[41]) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

endpackage

FILE: hw/rtl/cvg_mul_unit.sv
// ----------------------------------------------------------------------------
// cvg_mul_unit
// Shared Q1.30 scaling unit: offset times factor, shifted right by 30 with
// rounding half away from zero, saturated to 40 bits. One 40x16 multiplier
// forms the two partial products on successive cycles.
// ----------------------------------------------------------------------------
module cvg_mul_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [cvg_pkg::OFF_W-1:0]    operand,
	input  logic [cvg_pkg::FACTOR_W-1:0]        factor,
	output logic                                done,
	output logic signed [cvg_pkg::OFF_W-1:0]    product
);
	import cvg_pkg::*;

	localparam int LO_W   = 15;
	localparam int HI_W   = FACTOR_W - LO_W;
	localparam int PROD_W = OFF_W + HI_W;

	typedef enum logic [2:0] {M_IDLE, M_HI, M_LO, M_SUM, M_FIN} mstate_t;

	mstate_t             state_q;
	logic                neg_q;
	logic [OFF_W-1:0]    mag_q;
	logic [FACTOR_W-1:0] factor_q;
	logic [PROD_W-1:0]   ph_q;
	logic [PROD_W-1:0]   pl_q;
	logic signed [42:0]  quot_q;
	logic                done_q;
	logic signed [OFF_W-1:0] product_q;

	logic [HI_W-1:0]     mul_opnd;
	logic [PROD_W-1:0]   mul_out;
	logic [PROD_W-1:0]   round_sum;
	logic signed [42:0]  quot;
	logic signed [42:0]  signed_quot;

	assign mul_opnd = (state_q == M_HI) ? factor_q[FACTOR_W-1:LO_W]
	                                    : {1'b0, factor_q[LO_W-1:0]};
	assign mul_out  = mag_q * mul_opnd;

	assign round_sum = PROD_W'({ph_q[LO_W-1:0], {LO_W{1'b0}}}) + pl_q
	                   + (PROD_W'(1) << 29);
	assign quot = 43'(ph_q[PROD_W-1:LO_W]) + 43'(round_sum[PROD_W-1:30]);
	assign signed_quot = neg_q ? -quot_q : quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= M_IDLE;
			neg_q     <= 1'b0;
			mag_q     <= '0;
			factor_q  <= '0;
			ph_q      <= '0;
			pl_q      <= '0;
			quot_q    <= '0;
			done_q    <= 1'b0;
			product_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (start) begin
						neg_q    <= operand[OFF_W-1];
						mag_q    <= operand[OFF_W-1] ? OFF_W'(-operand) : OFF_W'(operand);
						factor_q <= factor;
						state_q  <= M_HI;
					end
				end
				M_HI: begin
					ph_q    <= mul_out;
					state_q <= M_LO;
				end
				M_LO: begin
					pl_q    <= mul_out;
					state_q <= M_SUM;
				end
				M_SUM: begin
					quot_q  <= quot;
					state_q <= M_FIN;
				end
				M_FIN: begin
					product_q <= sat40(signed_quot);
					done_q    <= 1'b1;
					state_q   <= M_IDLE;
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	assign done    = done_q;
	assign product = product_q;

endmodule

FILE: hw/rtl/circle_vertex_generator_core.sv
// ----------------------------------------------------------------------------
// circle_vertex_generator_core
// Emits the vertices of a regular polygon around a circle center, one word
// per vertex, by repeated rotation and scaling of the offset.
//
// Command channel: a word (center, radius) is taken at a clock edge with
// start high and busy low. busy stays high until the last vertex is out.
// Result channel: each vertex is on result for one cycle with result_strobe
// high; the receiver cannot stall it. last_vertex marks the final one.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high, indexes past step_cosine are dropped. Write only while idle.
// Sequence: after start is taken the first vertex is emitted; each further
// vertex needs four scalings by the shared multiply unit (tangent on y and x,
// then cosine on x and y) plus an emit state and a rotate state.
// Segment counts below 3 act as 3, above MAX_SEGMENTS as MAX_SEGMENTS.
// Reset: configuration returns to 64 segments and the default step factors;
// the sequencer goes idle.
// ----------------------------------------------------------------------------
module circle_vertex_generator_core #(
	parameter int MAX_SEGMENTS = cvg_pkg::CVG_MAX_SEGMENTS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  cvg_pkg::cvg_in_t                   cmd,
	output cvg_pkg::cvg_out_t                  result,
	output logic                               result_strobe,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cvg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cvg_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import cvg_pkg::*;

	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

	typedef enum logic [2:0] {S_IDLE, S_EMIT, S_TY, S_TX, S_ROT, S_CX, S_CY} state_t;

	state_t                  state_q;
	logic [SEG_W-1:0]        seg_q;
	logic [FACTOR_W-1:0]     tan_q;
	logic [FACTOR_W-1:0]     cos_q;
	logic signed [COORD_W-1:0] cx_q;
	logic signed [COORD_W-1:0] cy_q;
	logic signed [OFF_W-1:0] ox_q;
	logic signed [OFF_W-1:0] oy_q;
	logic signed [OFF_W-1:0] ty_q;
	logic signed [OFF_W-1:0] tx_q;
	logic signed [OFF_W-1:0] nx_q;
	logic signed [OFF_W-1:0] ny_q;
	logic [CNT_W-1:0]        n_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    mul_go_q;
	cvg_out_t                result_q;
	logic                    strobe_q;

	logic signed [OFF_W-1:0] mul_a;
	logic [FACTOR_W-1:0]     mul_f;
	logic                    mul_done;
	logic signed [OFF_W-1:0] mul_p;
	logic [CNT_W-1:0]        n_clamped;
	logic                    is_last;
	logic signed [41:0]      vx_sum;
	logic signed [41:0]      vy_sum;
	logic signed [42:0]      nx_sum;
	logic signed [42:0]      ny_sum;

	cvg_mul_unit u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_go_q),
		.operand (mul_a),
		.factor  (mul_f),
		.done    (mul_done),
		.product (mul_p)
	);

	always_comb begin
		case (state_q)
			S_TY: begin
				mul_a = oy_q;
				mul_f = tan_q;
			end
			S_TX: begin
				mul_a = ox_q;
				mul_f = tan_q;
			end
			S_CX: begin
				mul_a = nx_q;
				mul_f = cos_q;
			end
			S_CY: begin
				mul_a = ny_q;
				mul_f = cos_q;
			end
			default: begin
				mul_a = '0;
				mul_f = tan_q;
			end
		endcase
	end

	always_comb begin
		if (seg_q < SEG_W'(3)) begin
			n_clamped = CNT_W'(3);
		end else if (seg_q > SEG_W'(MAX_SEGMENTS)) begin
			n_clamped = CNT_W'(MAX_SEGMENTS);
		end else begin
			n_clamped = CNT_W'(seg_q);
		end
	end

	assign is_last = (cnt_q + CNT_W'(1)) == n_q;
	assign vx_sum  = 42'(cx_q) + 42'(ox_q);
	assign vy_sum  = 42'(cy_q) + 42'(oy_q);
	assign nx_sum  = 43'(ox_q) - 43'(ty_q);
	assign ny_sum  = 43'(oy_q) + 43'(tx_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= SEG_RESET;
			tan_q <= TAN_RESET;
			cos_q <= COS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SEGMENT_COUNT: seg_q <= cfg_data[SEG_W-1:0];
				CFG_STEP_TANGENT:  tan_q <= cfg_data[FACTOR_W-1:0];
				CFG_STEP_COSINE:   cos_q <= cfg_data[FACTOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// vertex sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cx_q     <= '0;
			cy_q     <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
			ty_q     <= '0;
			tx_q     <= '0;
			nx_q     <= '0;
			ny_q     <= '0;
			n_q      <= '0;
			cnt_q    <= '0;
			mul_go_q <= 1'b0;
			result_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			mul_go_q <= 1'b0;
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cx_q    <= cmd.center_x;
						cy_q    <= cmd.center_y;
						ox_q    <= OFF_W'(cmd.radius);
						oy_q    <= '0;
						n_q     <= n_clamped;
						cnt_q   <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					result_q.vertex_x    <= sat32(vx_sum);
					result_q.vertex_y    <= sat32(vy_sum);
					result_q.last_vertex <= is_last;
					strobe_q             <= 1'b1;
					if (is_last) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q    <= cnt_q + CNT_W'(1);
						mul_go_q <= 1'b1;
						state_q  <= S_TY;
					end
				end
				S_TY: begin
					if (mul_done) begin
						ty_q     <= mul_p;
						mul_go_q <= 1'b1;
						state_q  <= S_TX;
					end
				end
				S_TX: begin
					if (mul_done) begin
						tx_q    <= mul_p;
						state_q <= S_ROT;
					end
				end
				S_ROT: begin
					nx_q     <= sat40(nx_sum);
					ny_q     <= sat40(ny_sum);
					mul_go_q <= 1'b1;
					state_q  <= S_CX;
				end
				S_CX: begin
					if (mul_done) begin
						ox_q     <= mul_p;
						mul_go_q <= 1'b1;
						state_q  <= S_CY;
					end
				end
				S_CY: begin
					if (mul_done) begin
						oy_q    <= mul_p;
						state_q <= S_EMIT;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign cfg_ready     = 1'b1;
	assign result        = result_q;
	assign result_strobe = strobe_q;

	a_strobe_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result strobe without an active circle");

	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_EMIT))
		else $error("accepted command did not start emitting");

	a_mul_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> ((state_q == S_TY) || (state_q == S_TX)
		              || (state_q == S_CX) || (state_q == S_CY)))
		else $error("multiply result arrived while sequencer not waiting");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (cnt_q < n_q))
		else $error("vertex count ran past segment count");

endmodule
